### rtl/stk_pkg.sv
// shared types and codes for the stack with search
package stk_pkg;

    localparam int DATA_W = 32;
    localparam int FIELD_W = 5;
    localparam int TDATA_W = 48;

    typedef logic [1:0] action_t;
    typedef logic [2:0] status_t;
    typedef logic signed [DATA_W-1:0] word_t;

    localparam action_t ACT_PUSH   = 2'd0;
    localparam action_t ACT_POP    = 2'd1;
    localparam action_t ACT_LIST   = 2'd2;
    localparam action_t ACT_SEARCH = 2'd3;

    localparam status_t STAT_PUSHED    = 3'd0;
    localparam status_t STAT_POPPED    = 3'd1;
    localparam status_t STAT_EMPTY     = 3'd2;
    localparam status_t STAT_FULL      = 3'd3;
    localparam status_t STAT_ENTRY     = 3'd4;
    localparam status_t STAT_FOUND     = 3'd5;
    localparam status_t STAT_NOT_FOUND = 3'd6;

endpackage

### rtl/stk_mem.sv
// entry store: one write port, one registered read port
module stk_mem #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  stk_pkg::word_t        wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output stk_pkg::word_t        rdata
);

    stk_pkg::word_t mem [DEPTH];
    stk_pkg::word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/stack_with_search.sv
// top level: bounded lifo stack with list and search, sequencer over one read port
//
//  channel | dir | tdata (low bit up)               | tuser  | tlast
//  s_      | in  | value[31:0]                      | action | -
//  m_      | out | data[31:0] position[4:0] count[4:0] | status | last result
//
// list gives one result a cycle while the output is not stalled, and search
// checks one entry a cycle, both set by the single registered read port
// stepping from the top.
// synchronous active-low reset empties the stack; entries are not cleared.
// a stalled result holds the sequencer; one request is taken while the last
// result of the previous one still waits in the output register.
module stack_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stk_pkg::DATA_W-1:0]    s_tdata,  // value
    input  logic [1:0]                    s_tuser,  // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stk_pkg::TDATA_W-1:0]   m_tdata,  // data, position, count
    output logic [2:0]                    m_tuser,  // status
    output logic                          m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = stk_pkg::FIELD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_USE
    } state_t;

    state_t           state_reg, state_next;
    stk_pkg::action_t act_reg, act_next;
    stk_pkg::word_t   val_reg, val_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;

    logic             m_valid_reg, m_valid_next;
    stk_pkg::status_t m_status_reg, m_status_next;
    stk_pkg::word_t   m_data_reg, m_data_next;
    logic [FW-1:0]    m_pos_reg, m_pos_next;
    logic [FW-1:0]    m_cnt_reg, m_cnt_next;
    logic             m_last_reg, m_last_next;

    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    stk_pkg::word_t   mem_rdata;

    logic             out_free;
    logic             empty;
    logic             full;
    logic             at_last;
    logic             match;
    logic [CW-1:0]    idx_plus1;
    logic [CW-1:0]    addr_cur;
    logic [CW-1:0]    addr_nxt;

    logic             e_valid;
    stk_pkg::status_t e_status;
    stk_pkg::word_t   e_data;
    logic [CW-1:0]    e_pos;
    logic [CW-1:0]    e_cnt;
    logic             e_last;
    logic [CW+FW-1:0] e_pos_wide;
    logic [CW+FW-1:0] e_cnt_wide;

    stk_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (val_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign empty     = (cnt_reg == '0);
    assign full      = (cnt_reg == CW'(DEPTH));
    assign idx_plus1 = idx_reg + CW'(1);
    assign at_last   = (idx_plus1 == cnt_reg);
    assign addr_cur  = cnt_reg - CW'(1) - idx_reg;
    assign addr_nxt  = cnt_reg - CW'(2) - idx_reg;
    assign match     = (mem_rdata == val_reg);
    assign e_pos_wide = {{FW{1'b0}}, e_pos};
    assign e_cnt_wide = {{FW{1'b0}}, e_cnt};

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = addr_cur[AW-1:0];
        e_valid    = 1'b0;
        e_status   = stk_pkg::STAT_EMPTY;
        e_data     = '0;
        e_pos      = '0;
        e_cnt      = cnt_reg;
        e_last     = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    val_next   = s_tdata;
                    idx_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (act_reg)
                    stk_pkg::ACT_PUSH: begin
                        if (out_free) begin
                            e_valid    = 1'b1;
                            e_data     = val_reg;
                            state_next = ST_IDLE;
                            if (full) begin
                                e_status = stk_pkg::STAT_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                e_status = stk_pkg::STAT_PUSHED;
                                e_cnt    = cnt_reg + CW'(1);
                            end
                        end
                    end
                    stk_pkg::ACT_POP, stk_pkg::ACT_LIST: begin
                        if (empty) begin
                            if (out_free) begin
                                e_valid    = 1'b1;
                                e_status   = stk_pkg::STAT_EMPTY;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            mem_re     = 1'b1;
                            state_next = ST_USE;
                        end
                    end
                    stk_pkg::ACT_SEARCH: begin
                        if (empty) begin
                            if (out_free) begin
                                e_valid    = 1'b1;
                                e_status   = stk_pkg::STAT_NOT_FOUND;
                                e_data     = val_reg;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            mem_re     = 1'b1;
                            state_next = ST_USE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_USE: begin
                case (act_reg)
                    stk_pkg::ACT_POP: begin
                        if (out_free) begin
                            e_valid    = 1'b1;
                            e_status   = stk_pkg::STAT_POPPED;
                            e_data     = mem_rdata;
                            e_cnt      = cnt_reg - CW'(1);
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = ST_IDLE;
                        end
                    end
                    stk_pkg::ACT_LIST: begin
                        if (out_free) begin
                            e_valid  = 1'b1;
                            e_status = stk_pkg::STAT_ENTRY;
                            e_data   = mem_rdata;
                            e_pos    = idx_plus1;
                            e_last   = at_last;
                            if (at_last) begin
                                state_next = ST_IDLE;
                            end else begin
                                idx_next  = idx_plus1;
                                mem_re    = 1'b1;
                                mem_raddr = addr_nxt[AW-1:0];
                            end
                        end
                    end
                    stk_pkg::ACT_SEARCH: begin
                        if (match) begin
                            if (out_free) begin
                                e_valid    = 1'b1;
                                e_status   = stk_pkg::STAT_FOUND;
                                e_data     = val_reg;
                                e_pos      = idx_plus1;
                                state_next = ST_IDLE;
                            end
                        end else if (at_last) begin
                            if (out_free) begin
                                e_valid    = 1'b1;
                                e_status   = stk_pkg::STAT_NOT_FOUND;
                                e_data     = val_reg;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            idx_next  = idx_plus1;
                            mem_re    = 1'b1;
                            mem_raddr = addr_nxt[AW-1:0];
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_pos_next    = m_pos_reg;
        m_cnt_next    = m_cnt_reg;
        m_last_next   = m_last_reg;
        if (e_valid) begin
            m_valid_next  = 1'b1;
            m_status_next = e_status;
            m_data_next   = e_data;
            m_pos_next    = e_pos_wide[FW-1:0];
            m_cnt_next    = e_cnt_wide[FW-1:0];
            m_last_next   = e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        val_reg      <= val_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_pos_reg    <= m_pos_next;
        m_cnt_reg    <= m_cnt_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(stk_pkg::TDATA_W - stk_pkg::DATA_W - 2 * FW){1'b0}},
                       m_cnt_reg, m_pos_reg, m_data_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
